// ===== sv/base64_decoder_core_macros.svh =====
// Assertion macros shared by the base64 decoder checker.
`ifndef BASE64_DECODER_CORE_MACROS_SVH
`define BASE64_DECODER_CORE_MACROS_SVH

// Checked on every rising edge of clk while arst_n is high.
`define B64D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define B64D_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
// Types, constants and the character lookup of the base64 decoder.
package b64d_pkg;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_FOURTH = 2'd3;

	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PAD   = 8'h3D;

	localparam logic [7:0] SEXT_LO_BASE  = 8'd26;
	localparam logic [7:0] SEXT_DIG_BASE = 8'd52;
	localparam logic [5:0] SEXT_PLUS     = 6'd62;
	localparam logic [5:0] SEXT_SLASH    = 6'd63;

	localparam logic [1:0] FULL_GROUP_BYTES = 2'd3;

	// One queue entry: a finished group, or the error close of a stream.
	typedef struct packed {
		logic [23:0] triple;
		logic [1:0]  nbytes;
		logic        err_end;
		logic        eos;
	} b64d_entry_t;

	// Returns {in_alphabet, sextet}.
	function automatic logic [6:0] b64d_sextet(input logic [7:0] c);
		logic [7:0] d;
		logic [6:0] r;
		begin
			d = 8'd0;
			r = 7'd0;
			if (c >= CH_UP_A && c <= CH_UP_Z) begin
				d = c - CH_UP_A;
				r = {1'b1, d[5:0]};
			end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
				d = c - CH_LO_A + SEXT_LO_BASE;
				r = {1'b1, d[5:0]};
			end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
				d = c - CH_DIG_0 + SEXT_DIG_BASE;
				r = {1'b1, d[5:0]};
			end else if (c == CH_PLUS) begin
				r = {1'b1, SEXT_PLUS};
			end else if (c == CH_SLASH) begin
				r = {1'b1, SEXT_SLASH};
			end
			return r;
		end
	endfunction

endpackage

// ===== sv/base64_decoder_core.sv =====
// Streaming base64 decoder: one character in and one byte out per cycle when not stalled.
// With the queue empty, the first result of a character passes through the group queue
// and then the back-end output register on its way to the outputs.
// Throughput: one character per cycle while the queue is not full; the back end gives one
// result beat per cycle while out_stall is low, so three bytes per four characters keep up,
// and the queue absorbs output stalls. Input stalls only while the group queue is full.
// Reset (arst_n low, asynchronous) clears group state, queue and output valid.
module base64_decoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       decode_error,
	output logic       end_of_stream,
	output logic       last_of_run
);
	import b64d_pkg::*;

	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_valid;
	b64d_entry_t push_entry;
	b64d_entry_t head;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.queue_full (q_full),
		.char_in    (char_in),
		.last_char  (last_char),
		.in_stall   (in_stall),
		.push       (push),
		.push_entry (push_entry)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_valid),
		.head       (head)
	);

	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.head          (head),
		.out_stall     (out_stall),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.decode_error  (decode_error),
		.end_of_stream (end_of_stream),
		.last_of_run   (last_of_run)
	);

endmodule

// ===== sv/b64d_front.sv =====
// Front end: takes characters, tracks the group, and queues finished groups.
module b64d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 queue_full,
	input  logic [7:0]           char_in,
	input  logic                 last_char,
	output logic                 in_stall,
	output logic                 push,
	output b64d_pkg::b64d_entry_t push_entry
);
	import b64d_pkg::*;

	logic [1:0]  pos_q;
	logic [17:0] accum_q;
	logic        third_pad_q;
	logic        err_q;

	logic [6:0]  sx;
	logic [5:0]  sv;
	logic        is_pad;
	logic        accept;
	logic        err_next;
	logic        group_done;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	always_comb begin
		sx       = b64d_sextet(char_in);
		sv       = sx[5:0];
		is_pad   = (char_in == CH_PAD);
		err_next = err_q
			|| ((pos_q == POS_FIRST || pos_q == POS_SECOND) && !sx[6])
			|| (last_char && pos_q != POS_FOURTH);
		group_done = (pos_q == POS_FOURTH) && !err_next;
		push       = accept && (group_done || last_char);

		push_entry.triple  = {accum_q, sv};
		push_entry.err_end = !group_done;
		push_entry.eos     = last_char;
		if (last_char) begin
			push_entry.nbytes = FULL_GROUP_BYTES - {1'b0, third_pad_q} - {1'b0, is_pad};
		end else begin
			push_entry.nbytes = FULL_GROUP_BYTES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_FIRST;
			accum_q     <= 18'd0;
			third_pad_q <= 1'b0;
			err_q       <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				pos_q       <= POS_FIRST;
				accum_q     <= 18'd0;
				third_pad_q <= 1'b0;
				err_q       <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
				err_q <= err_next;
				case (pos_q)
					POS_FIRST: begin
						accum_q     <= {12'd0, sv};
						third_pad_q <= 1'b0;
					end
					POS_SECOND: begin
						accum_q <= {accum_q[11:0], sv};
					end
					POS_THIRD: begin
						accum_q     <= {accum_q[11:0], sv};
						third_pad_q <= is_pad;
					end
					default: begin
						accum_q <= accum_q;
					end
				endcase
			end
		end
	end

endmodule

// ===== sv/b64d_queue.sv =====
// Short queue of finished groups between the front and back ends.
module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64d_pkg::b64d_entry_t push_entry,
	input  logic                 pop,
	output logic                 full,
	output logic                 not_empty,
	output b64d_pkg::b64d_entry_t head
);
	import b64d_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_entry_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/b64d_back.sv =====
// Back end: splits queued groups into bytes, one result beat per cycle while out_stall is low.
module b64d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  b64d_pkg::b64d_entry_t head,
	input  logic                 out_stall,
	output logic                 pop,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic                 has_byte,
	output logic                 decode_error,
	output logic                 end_of_stream,
	output logic                 last_of_run
);
	import b64d_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       has_q;
	logic       err_q;
	logic       eos_q;
	logic       lor_q;

	logic       load;
	logic       fin;
	logic [7:0] sel_byte;

	always_comb begin
		load = q_valid && (!valid_q || !out_stall);
		fin  = head.err_end || (idx_q == head.nbytes - 2'd1);
		pop  = load && fin;
		case (idx_q)
			2'd0:    sel_byte = head.triple[23:16];
			2'd1:    sel_byte = head.triple[15:8];
			default: sel_byte = head.triple[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= fin ? 2'd0 : idx_q + 2'd1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.err_end ? 8'd0 : sel_byte;
			has_q  <= !head.err_end;
			err_q  <= head.err_end;
			eos_q  <= fin && head.eos;
			lor_q  <= fin;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign has_byte      = has_q;
	assign decode_error  = err_q;
	assign end_of_stream = eos_q;
	assign last_of_run   = lor_q;

endmodule

// ===== sv/b64d_checker.sv =====
// Port-level checks of the base64 decoder and their binding to the top level.
`include "base64_decoder_core_macros.svh"

module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input logic       decode_error,
	input logic       end_of_stream,
	input logic       last_of_run
);

	// A stalled result beat holds still.
	`B64D_ASSERT(a_out_hold,
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(has_byte)
			&& $stable(last_of_run),
		"stalled output beat changed")

	// An error close carries no byte and closes the stream.
	`B64D_ASSERT(a_err_close,
		out_valid && decode_error |-> !has_byte && out_byte == 8'd0 && end_of_stream
			&& last_of_run,
		"malformed error beat")

	// The stream close is always the final beat of its character.
	`B64D_ASSERT(a_eos_last, out_valid && end_of_stream |-> last_of_run, "end of stream without last of run")

	// A beat without a byte only appears as an error close.
	`B64D_ASSERT(a_nobyte_err, out_valid && !has_byte |-> decode_error, "empty beat without error")

	// Reset empties the output.
	`B64D_ASSERT_ALWAYS(a_reset_clear, !arst_n |-> out_valid !== 1'b1, "output valid during reset")

endmodule

bind base64_decoder_core b64d_checker u_b64d_checker (.*);

// ===== tb/sv/base64_decoder_core_test.sv =====
// Self-checking testbench for the streaming base64 decoder core.
module base64_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import b64d_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 150;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       err;
		logic       eos;
		logic       lor;
	} dec_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_in = 8'h00;
	logic       last_char = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       decode_error;
	logic       end_of_stream;
	logic       last_of_run;

	// Decoder state mirrored by the predictor.
	logic [1:0]  grp_pos;
	logic [17:0] sextets;
	logic        third_pad;
	logic        stream_bad;

	dec_result_t decoded_q[$];

	int  fail_count = 0;
	int  chars_sent = 0;
	int  beats_checked = 0;
	int  streams_done = 0;
	int  streams_failed = 0;
	int  cycle_count = 0;
	int  in_stall_cycles = 0;
	int  rx_wait = 0;
	bit  rx_idle = 1'b1;
	logic rx_hold = 1'b0;
	event hold_start;

	base64_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_in      (char_in),
		.last_char    (last_char),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.has_byte     (has_byte),
		.decode_error (decode_error),
		.end_of_stream(end_of_stream),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Alphabet lookup; -1 for anything outside it, the pad included.
	function automatic int sextet_value(input logic [7:0] c);
		if (c >= CH_UP_A && c <= CH_UP_Z)
			return int'(c - CH_UP_A);
		if (c >= CH_LO_A && c <= CH_LO_Z)
			return int'(c - CH_LO_A) + int'(SEXT_LO_BASE);
		if (c >= CH_DIG_0 && c <= CH_DIG_9)
			return int'(c - CH_DIG_0) + int'(SEXT_DIG_BASE);
		if (c == CH_PLUS)
			return int'(SEXT_PLUS);
		if (c == CH_SLASH)
			return int'(SEXT_SLASH);
		return -1;
	endfunction

	function automatic logic [7:0] random_alpha();
		int idx;
		idx = $urandom_range(0, 63);
		if (idx < 26)
			return CH_UP_A + 8'(idx);
		if (idx < 52)
			return CH_LO_A + 8'(idx - 26);
		if (idx < 62)
			return CH_DIG_0 + 8'(idx - 52);
		return (idx == 62) ? CH_PLUS : CH_SLASH;
	endfunction

	function automatic void clear_group_state();
		grp_pos = POS_FIRST;
		sextets = '0;
		third_pad = 1'b0;
		stream_bad = 1'b0;
	endfunction

	// Works out the result beats that one accepted character produces.
	function automatic void decode_char(input logic [7:0] c, input logic is_last);
		int          sx;
		logic [5:0]  sv;
		logic        pad;
		logic [23:0] triple;
		int          count;
		dec_result_t r;
		sx = sextet_value(c);
		sv = (sx < 0) ? 6'd0 : 6'(sx);
		pad = (c == CH_PAD);
		if (grp_pos <= POS_SECOND && sx < 0)
			stream_bad = 1'b1;
		case (grp_pos)
			POS_FIRST: begin
				sextets = {12'd0, sv};
				third_pad = 1'b0;
			end
			POS_SECOND: sextets = {sextets[11:0], sv};
			POS_THIRD: begin
				sextets = {sextets[11:0], sv};
				third_pad = pad;
			end
			default: ;
		endcase
		if (is_last && grp_pos != POS_FOURTH)
			stream_bad = 1'b1;
		if (grp_pos == POS_FOURTH && !stream_bad) begin
			triple = {sextets, sv};
			count = 3;
			if (is_last)
				count = count - int'(third_pad) - int'(pad);
			for (int i = 0; i < count; i++) begin
				r.data = triple[23 - 8 * i -: 8];
				r.has = 1'b1;
				r.err = 1'b0;
				r.eos = is_last && (i == count - 1);
				r.lor = (i == count - 1);
				decoded_q.push_back(r);
			end
		end else if (is_last) begin
			r = '{data: 8'h00, has: 1'b0, err: 1'b1, eos: 1'b1, lor: 1'b1};
			decoded_q.push_back(r);
			streams_failed++;
		end
		if (is_last) begin
			streams_done++;
			clear_group_state();
		end else begin
			grp_pos = grp_pos + 2'd1;
		end
	endfunction

	task automatic send_char(input logic [7:0] c, input logic is_last, input bit idle);
		int gap;
		gap = idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		last_char <= is_last;
		do @(posedge clk); while (in_stall);
		decode_char(c, is_last);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input bit idle);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1, idle);
	endtask

	// Mostly well-formed streams with random content; the rest carry noise
	// characters or end short of a full group.
	task automatic send_random_stream(input bit idle, inout int sent);
		int groups, mode, len, pads, k;
		logic [7:0] ch;
		groups = $urandom_range(1, 4);
		mode = $urandom_range(0, 9);
		len = groups * 4;
		pads = (mode < 7) ? $urandom_range(0, 2) : 0;
		if (mode == 9)
			len = len - $urandom_range(1, 3);
		for (k = 0; k < len; k++) begin
			ch = random_alpha();
			if (mode == 7 || mode == 8) begin
				if ($urandom_range(0, 4) == 0)
					ch = 8'($urandom_range(0, 255));
			end else if (mode < 7) begin
				if (k >= len - pads)
					ch = CH_PAD;
				else if (k < len - 4 && $urandom_range(0, 15) == 0)
					ch = CH_PAD;
			end
			send_char(ch, k == len - 1, idle);
			sent++;
		end
	endtask

	task automatic finish_sending();
		in_valid <= 1'b0;
		last_char <= 1'b0;
	endtask

	task automatic test_padding();
		send_text("TWE=", 1'b1);
		send_text("TQ==", 1'b1);
	endtask

	task automatic test_full_group();
		send_text("zz9/", 1'b1);
	endtask

	// A pad up front errors out; junk in the back half decodes as zero.
	task automatic test_bad_chars();
		send_text("A=AA", 1'b1);
		send_char("A", 1'b0, 1'b1);
		send_char("B", 1'b0, 1'b1);
		send_char(8'h00, 1'b0, 1'b1);
		send_char(8'hFF, 1'b1, 1'b1);
	endtask

	// A pad inside a group before the last still gives three bytes; the stream then
	// ends two characters into a group.
	task automatic test_inner_pad_short_end();
		send_text("AB=AQQ", 1'b1);
	endtask

	task automatic test_random_streams(input int target);
		int sent;
		sent = 0;
		rx_idle <= 1'b1;
		while (sent < target)
			send_random_stream(1'b1, sent);
	endtask

	task automatic test_back_to_back(input int target);
		int sent;
		sent = 0;
		rx_idle <= 1'b0;
		while (sent < target)
			send_random_stream(1'b0, sent);
		rx_idle <= 1'b1;
	endtask

	// The output side holds off long enough for the group queue to fill.
	task automatic test_backpressure(input int target);
		int sent;
		sent = 0;
		-> hold_start;
		while (sent < target)
			send_random_stream(1'b0, sent);
	endtask

	initial begin : hold_ctrl
		forever begin
			@(hold_start);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	function automatic void flag_mismatch(input string what, input dec_result_t want,
			input dec_result_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("%s at cycle %0d: expected byte %02h has %b err %b eos %b last %b",
				what, cycle_count, want.data, want.has, want.err, want.eos, want.lor);
			$display("    got byte %02h has %b err %b eos %b last %b",
				got.data, got.has, got.err, got.eos, got.lor);
		end
	endfunction

	always @(posedge clk) begin : rx_side
		dec_result_t got;
		dec_result_t want;
		logic        stall_next;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_byte, has_byte, decode_error, end_of_stream, last_of_run};
			if (decoded_q.size() == 0) begin
				flag_mismatch("Unexpected beat", '0, got);
			end else begin
				want = decoded_q.pop_front();
				if (got !== want)
					flag_mismatch("Beat mismatch", want, got);
			end
			beats_checked++;
			rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
		end
		stall_next = rx_hold;
		if (rx_wait > 0) begin
			stall_next = 1'b1;
			rx_wait--;
		end
		out_stall <= stall_next;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (in_valid && in_stall)
			in_stall_cycles <= in_stall_cycles + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d beats still expected",
				cycle_count, decoded_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clear_group_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_padding();
		test_full_group();
		test_bad_chars();
		test_inner_pad_short_end();
		test_random_streams(50);
		test_back_to_back(30);
		test_backpressure(40);
		test_random_streams(20);
		finish_sending();

		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d characters in %0d streams, %0d of them ending in error.",
			chars_sent, streams_done, streams_failed);
		$display("Checked %0d result beats; input was held back for %0d cycles.",
			beats_checked, in_stall_cycles);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
